FILE: hw/rtl/circle_pair_elastic_collision_assert.svh
// Assertion macros for the checker file of the circle collision block.
`ifndef CIRCLE_PAIR_ELASTIC_COLLISION_ASSERT_SVH
`define CIRCLE_PAIR_ELASTIC_COLLISION_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define CCOLL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, active through reset as well.
`define CCOLL_ASSERT_NXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ccoll_pkg.sv
// Package with the shared constants and helpers of the circle collision block.
package ccoll_pkg;

   // Default coordinate format: signed Q16.8.
   localparam int COORD_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF   = 8;

   // Radius is a whole number of units; mass is radius squared.
   localparam int RADIUS_WIDTH = 8;
   // Twice a mass, or the sum of two masses, fits this width.
   localparam int MASS_WIDTH   = 2 * RADIUS_WIDTH + 1;

   // Larger of two elaboration-time integers.
   function automatic int ccoll_max(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

FILE: hw/rtl/circle_pair_elastic_collision.sv
// Top level of the circle pair collision block: overlap test, separation and impulse.
//
//   channel  | ports         | handshake
//   ---------+---------------+--------------------------------------------
//   request  | req_*         | start high and busy low takes one word
//   response | rsp_*         | rsp_valid marks a word for one cycle
//
// One word is taken every cycle; busy stays low.
// Latency is set by the bit-per-stage impulse divider after the products, beside the square root.
// Reset clears only the valid bits of the pipeline and the hit flag.
// The receiver cannot stall, so the pipeline always advances.
module circle_pair_elastic_collision import ccoll_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_a_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_a_vel_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_vel_y,
   input  logic        [RADIUS_WIDTH-1:0] req_a_radius,
   input  logic signed [COORD_WIDTH-1:0] req_b_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_vel_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_vel_y,
   input  logic        [RADIUS_WIDTH-1:0] req_b_radius,
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_new_a_pos_x,
   output logic signed [COORD_WIDTH-1:0] rsp_new_a_pos_y,
   output logic signed [COORD_WIDTH-1:0] rsp_new_a_vel_x,
   output logic signed [COORD_WIDTH-1:0] rsp_new_a_vel_y,
   output logic signed [COORD_WIDTH-1:0] rsp_new_b_pos_x,
   output logic signed [COORD_WIDTH-1:0] rsp_new_b_pos_y,
   output logic signed [COORD_WIDTH-1:0] rsp_new_b_vel_x,
   output logic signed [COORD_WIDTH-1:0] rsp_new_b_vel_y,
   output logic                          rsp_hit
);

   localparam int CW   = COORD_WIDTH;
   localparam int DXW  = CW + 1;
   localparam int SW   = RADIUS_WIDTH + 1 + FRAC_BITS;
   localparam int CMPW = ccoll_max(DXW, SW);
   localparam int MW   = MASS_WIDTH;
   localparam int PW   = SW + CW + 2;
   localparam int DOTW = PW + 1;
   localparam int DTW  = DOTW - 1;
   localparam int DLO  = DTW / 2;
   localparam int DHI  = DTW - DLO;
   localparam int KW   = MW + SW;
   localparam int NV   = KW + DTW;
   localparam int DV   = MW + 2 * SW;
   localparam int QV   = ccoll_max(CW + 2, 2 * SW - 2);
   localparam int QS   = QV + 2 - SW;
   localparam int NS   = 2 * SW + QS;
   localparam int DS   = SW + 1;
   localparam int FW   = ccoll_max(CW, QV) + 2;
   localparam int LAT  = QV + 10;
   localparam int PAYD = QV + 9;
   localparam int SIDD = QV + 5;

   localparam logic signed [FW-1:0] SAT_HI = {{(FW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [FW-1:0] SAT_LO = {{(FW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   typedef struct packed {
      logic signed [CW-1:0]           ax;
      logic signed [CW-1:0]           ay;
      logic signed [CW-1:0]           avx;
      logic signed [CW-1:0]           avy;
      logic        [RADIUS_WIDTH-1:0] ra;
      logic signed [CW-1:0]           bx;
      logic signed [CW-1:0]           by;
      logic signed [CW-1:0]           bvx;
      logic signed [CW-1:0]           bvy;
      logic        [RADIUS_WIDTH-1:0] rb;
   } pay_type;

   typedef struct packed {
      logic near;
      logic sdx;
      logic sdy;
      logic sdot;
   } side_type;

   typedef struct packed {
      logic [SW-1:0] adx;
      logic [SW-1:0] ady;
      logic [SW-1:0] s;
   } sep_type;

   // Saturating add or subtract of a quotient magnitude to a coordinate.
   function automatic logic [CW-1:0] sat_add(input logic signed [CW-1:0] base,
                                             input logic [QV-1:0] mag, input logic add);
      logic signed [FW-1:0] bx;
      logic signed [FW-1:0] mx;
      logic signed [FW-1:0] wide;
      bx   = FW'(base);
      mx   = signed'(FW'(mag));
      wide = add ? (bx + mx) : (bx - mx);
      if (wide > SAT_HI) begin
         return SAT_HI[CW-1:0];
      end else if (wide < SAT_LO) begin
         return SAT_LO[CW-1:0];
      end
      return wide[CW-1:0];
   endfunction

   pay_type  pay_in;
   pay_type  pay_ff  [0:PAYD-1];
   side_type side_ff [0:SIDD-1];
   sep_type  sep_ff  [0:SW-1];
   logic [LAT-1:0] vld_ff;

   // Stage A: differences and the radius sum.
   logic signed [DXW-1:0] dx_a_ff, dy_a_ff, dvx_a_ff, dvy_a_ff;
   logic        [SW-1:0]  s_a_ff;

   // Stage B: magnitudes and the box test.
   logic [DXW-1:0]              adx_full, ady_full;
   logic                        inr_b_ff, sdx_b_ff, sdy_b_ff;
   logic [SW-1:0]               adx_b_ff, ady_b_ff, s_b_ff;
   logic signed [SW:0]          dxs_b_ff, dys_b_ff;
   logic signed [DXW-1:0]       dvx_b_ff, dvy_b_ff;
   logic [2*RADIUS_WIDTH-1:0]   m1_b_ff, m2_b_ff;

   // Stage C: squares and dot product terms.
   logic [2*SW-1:0]     dx2_c_ff, dy2_c_ff, s2_c_ff;
   logic signed [PW-1:0] px_c_ff, py_c_ff;
   logic [MW-1:0]       msum_c_ff, m1x2_c_ff, m2x2_c_ff;
   logic                inr_c_ff, sdx_c_ff, sdy_c_ff;
   logic [SW-1:0]       adx_c_ff, ady_c_ff, s_c_ff;

   // Stage D: squared distance, dot product and the overlap decision.
   logic [2*SW:0]          d2_full;
   logic [2*SW-1:0]        d2_d_ff;
   logic signed [DOTW-1:0] dot_d_ff;
   logic                   near_d_ff, sdx_d_ff, sdy_d_ff;
   logic [SW-1:0]          adx_d_ff, ady_d_ff, s_d_ff;
   logic [MW-1:0]          msum_d_ff, m1x2_d_ff, m2x2_d_ff;

   // Stage E onward for the impulse.
   logic [DTW-1:0]     adot;
   logic [KW-1:0]      k_e_ff [0:3];
   logic [DV-1:0]      vden_e_ff, vden_f_ff, vden_g_ff;
   logic [KW+DLO-1:0]  plo_f_ff [0:3];
   logic [KW+DHI-1:0]  phi_f_ff [0:3];
   logic [NV-1:0]      vnum_g_ff [0:3];
   logic [QV-1:0]      vq [0:3];

   // Separation path after the square root.
   logic [SW-1:0]  center_dist;
   logic [SW-1:0]  gap;
   logic [2*SW-1:0] snum_ff [0:1];
   logic [DS-1:0]  sden_ff;
   logic [QS-1:0]  sq [0:1];

   // Output word.
   logic [CW-1:0] o_ax_ff, o_ay_ff, o_avx_ff, o_avy_ff;
   logic [CW-1:0] o_bx_ff, o_by_ff, o_bvx_ff, o_bvy_ff;
   logic          hit_ff;

   assign busy = 1'b0;

   assign pay_in = '{ax: req_a_pos_x, ay: req_a_pos_y, avx: req_a_vel_x, avy: req_a_vel_y,
                     ra: req_a_radius, bx: req_b_pos_x, by: req_b_pos_y,
                     bvx: req_b_vel_x, bvy: req_b_vel_y, rb: req_b_radius};

   // Valid bits travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
      end
   end

   // The request word rides along to the last stage, as the base of the result or as the no-overlap output.
   always_ff @(posedge clock) begin
      pay_ff[0] <= pay_in;
      for (int i = 1; i < PAYD; i++) begin
         pay_ff[i] <= pay_ff[i-1];
      end
   end

   // Stage A.
   always_ff @(posedge clock) begin
      dx_a_ff  <= DXW'(req_a_pos_x) - DXW'(req_b_pos_x);
      dy_a_ff  <= DXW'(req_a_pos_y) - DXW'(req_b_pos_y);
      dvx_a_ff <= DXW'(req_a_vel_x) - DXW'(req_b_vel_x);
      dvy_a_ff <= DXW'(req_a_vel_y) - DXW'(req_b_vel_y);
      s_a_ff   <= SW'({1'b0, req_a_radius} + {1'b0, req_b_radius}) << FRAC_BITS;
   end

   // Stage B.
   assign adx_full = dx_a_ff[DXW-1] ? DXW'(-dx_a_ff) : DXW'(dx_a_ff);
   assign ady_full = dy_a_ff[DXW-1] ? DXW'(-dy_a_ff) : DXW'(dy_a_ff);

   always_ff @(posedge clock) begin
      inr_b_ff <= (CMPW'(adx_full) < CMPW'(s_a_ff)) && (CMPW'(ady_full) < CMPW'(s_a_ff));
      sdx_b_ff <= dx_a_ff[DXW-1];
      sdy_b_ff <= dy_a_ff[DXW-1];
      adx_b_ff <= SW'(adx_full);
      ady_b_ff <= SW'(ady_full);
      dxs_b_ff <= (SW+1)'(dx_a_ff);
      dys_b_ff <= (SW+1)'(dy_a_ff);
      dvx_b_ff <= dvx_a_ff;
      dvy_b_ff <= dvy_a_ff;
      s_b_ff   <= s_a_ff;
      m1_b_ff  <= (2*RADIUS_WIDTH)'(pay_ff[0].ra) * (2*RADIUS_WIDTH)'(pay_ff[0].ra);
      m2_b_ff  <= (2*RADIUS_WIDTH)'(pay_ff[0].rb) * (2*RADIUS_WIDTH)'(pay_ff[0].rb);
   end

   // Stage C.
   always_ff @(posedge clock) begin
      dx2_c_ff  <= (2*SW)'(adx_b_ff) * (2*SW)'(adx_b_ff);
      dy2_c_ff  <= (2*SW)'(ady_b_ff) * (2*SW)'(ady_b_ff);
      s2_c_ff   <= (2*SW)'(s_b_ff) * (2*SW)'(s_b_ff);
      px_c_ff   <= PW'(dxs_b_ff) * PW'(dvx_b_ff);
      py_c_ff   <= PW'(dys_b_ff) * PW'(dvy_b_ff);
      msum_c_ff <= MW'(m1_b_ff) + MW'(m2_b_ff);
      m1x2_c_ff <= {m1_b_ff, 1'b0};
      m2x2_c_ff <= {m2_b_ff, 1'b0};
      inr_c_ff  <= inr_b_ff;
      sdx_c_ff  <= sdx_b_ff;
      sdy_c_ff  <= sdy_b_ff;
      adx_c_ff  <= adx_b_ff;
      ady_c_ff  <= ady_b_ff;
      s_c_ff    <= s_b_ff;
   end

   // Stage D.
   assign d2_full = (2*SW+1)'(dx2_c_ff) + (2*SW+1)'(dy2_c_ff);

   always_ff @(posedge clock) begin
      d2_d_ff   <= d2_full[2*SW-1:0];
      dot_d_ff  <= DOTW'(px_c_ff) + DOTW'(py_c_ff);
      near_d_ff <= inr_c_ff && (d2_full != '0) && (d2_full < (2*SW+1)'(s2_c_ff));
      sdx_d_ff  <= sdx_c_ff;
      sdy_d_ff  <= sdy_c_ff;
      adx_d_ff  <= adx_c_ff;
      ady_d_ff  <= ady_c_ff;
      s_d_ff    <= s_c_ff;
      msum_d_ff <= msum_c_ff;
      m1x2_d_ff <= m1x2_c_ff;
      m2x2_d_ff <= m2x2_c_ff;
   end

   // Flags needed at the last stage.
   always_ff @(posedge clock) begin
      side_ff[0] <= '{near: near_d_ff, sdx: sdx_d_ff, sdy: sdy_d_ff,
                      sdot: dot_d_ff[DOTW-1]};
      for (int i = 1; i < SIDD; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   // Stage E: impulse factors 2*m*|d| and the common divisor.
   assign adot = dot_d_ff[DOTW-1] ? DTW'(-dot_d_ff) : DTW'(dot_d_ff);

   always_ff @(posedge clock) begin
      k_e_ff[0] <= KW'(m2x2_d_ff) * KW'(adx_d_ff);
      k_e_ff[1] <= KW'(m2x2_d_ff) * KW'(ady_d_ff);
      k_e_ff[2] <= KW'(m1x2_d_ff) * KW'(adx_d_ff);
      k_e_ff[3] <= KW'(m1x2_d_ff) * KW'(ady_d_ff);
      vden_e_ff <= DV'(msum_d_ff) * DV'(d2_d_ff);
   end

   logic [DTW-1:0] adot_e_ff;

   always_ff @(posedge clock) begin
      adot_e_ff <= adot;
      vden_f_ff <= vden_e_ff;
      vden_g_ff <= vden_f_ff;
   end

   // Stages F and G: the wide numerator in two partial products, then their sum.
   for (genvar v = 0; v < 4; v++) begin : g_vel
      always_ff @(posedge clock) begin
         plo_f_ff[v]  <= (KW+DLO)'(k_e_ff[v]) * (KW+DLO)'(adot_e_ff[DLO-1:0]);
         phi_f_ff[v]  <= (KW+DHI)'(k_e_ff[v]) * (KW+DHI)'(adot_e_ff[DTW-1:DLO]);
         vnum_g_ff[v] <= NV'(plo_f_ff[v]) + (NV'(phi_f_ff[v]) << DLO);
      end

      ccoll_div #(
         .NW(NV),
         .DW(DV),
         .QW(QV)
      ) u_vdiv (
         .clock(clock),
         .num  (vnum_g_ff[v]),
         .den  (vden_g_ff),
         .quo  (vq[v])
      );
   end

   // Distance from the squared distance.
   ccoll_sqrt #(
      .RW(SW)
   ) u_sqrt (
      .clock(clock),
      .rad  (d2_d_ff),
      .root (center_dist)
   );

   // Separation operands wait for the square root.
   always_ff @(posedge clock) begin
      sep_ff[0] <= '{adx: adx_d_ff, ady: ady_d_ff, s: s_d_ff};
      for (int i = 1; i < SW; i++) begin
         sep_ff[i] <= sep_ff[i-1];
      end
   end

   // Overlap depth times each axis distance, over twice the distance.
   assign gap = sep_ff[SW-1].s - center_dist;

   always_ff @(posedge clock) begin
      snum_ff[0] <= (2*SW)'(sep_ff[SW-1].adx) * (2*SW)'(gap);
      snum_ff[1] <= (2*SW)'(sep_ff[SW-1].ady) * (2*SW)'(gap);
      sden_ff    <= {center_dist, 1'b0};
   end

   for (genvar p = 0; p < 2; p++) begin : g_sep
      ccoll_div #(
         .NW(NS),
         .DW(DS),
         .QW(QS)
      ) u_sdiv (
         .clock(clock),
         .num  (NS'(snum_ff[p])),
         .den  (sden_ff),
         .quo  (sq[p])
      );
   end

   // Last stage: apply signs, saturate, or pass the word through unchanged.
   side_type side_z;
   pay_type  pay_z;
   logic     negx, negy;

   assign side_z = side_ff[SIDD-1];
   assign pay_z  = pay_ff[PAYD-1];
   assign negx   = side_z.sdx ^ side_z.sdot;
   assign negy   = side_z.sdy ^ side_z.sdot;

   always_ff @(posedge clock) begin
      if (side_z.near) begin
         o_ax_ff  <= sat_add(pay_z.ax, QV'(sq[0]), !side_z.sdx);
         o_ay_ff  <= sat_add(pay_z.ay, QV'(sq[1]), !side_z.sdy);
         o_bx_ff  <= sat_add(pay_z.bx, QV'(sq[0]), side_z.sdx);
         o_by_ff  <= sat_add(pay_z.by, QV'(sq[1]), side_z.sdy);
         o_avx_ff <= sat_add(pay_z.avx, vq[0], negx);
         o_avy_ff <= sat_add(pay_z.avy, vq[1], negy);
         o_bvx_ff <= sat_add(pay_z.bvx, vq[2], !negx);
         o_bvy_ff <= sat_add(pay_z.bvy, vq[3], !negy);
      end else begin
         o_ax_ff  <= pay_z.ax;
         o_ay_ff  <= pay_z.ay;
         o_bx_ff  <= pay_z.bx;
         o_by_ff  <= pay_z.by;
         o_avx_ff <= pay_z.avx;
         o_avy_ff <= pay_z.avy;
         o_bvx_ff <= pay_z.bvx;
         o_bvy_ff <= pay_z.bvy;
      end
   end

   // The hit flag only shows with a valid word.
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= vld_ff[LAT-2] && side_z.near;
      end
   end

   assign rsp_valid       = vld_ff[LAT-1];
   assign rsp_hit         = hit_ff;
   assign rsp_new_a_pos_x = o_ax_ff;
   assign rsp_new_a_pos_y = o_ay_ff;
   assign rsp_new_a_vel_x = o_avx_ff;
   assign rsp_new_a_vel_y = o_avy_ff;
   assign rsp_new_b_pos_x = o_bx_ff;
   assign rsp_new_b_pos_y = o_by_ff;
   assign rsp_new_b_vel_x = o_bvx_ff;
   assign rsp_new_b_vel_y = o_bvy_ff;

endmodule

FILE: hw/rtl/ccoll_div.sv
// Pipelined restoring divider with round to nearest and clamp on overflow.
module ccoll_div import ccoll_pkg::*; #(
   parameter int NW = 34,
   parameter int DW = 18,
   parameter int QW = 17
) (
   input  logic          clock,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);

   localparam int XW = ccoll_max(NW - QW, DW);

   logic [DW-1:0] rem_ff [0:QW];
   logic [QW-1:0] low_ff [0:QW];
   logic [DW-1:0] den_ff [0:QW];
   logic [QW-1:0] q_ff   [0:QW];
   logic          ovf_ff [0:QW];
   logic [QW-1:0] quo_ff;

   logic [XW-1:0] head;
   logic          rnd;
   logic [QW:0]   qsum;

   // The upper part of the dividend must stay below the divisor, else the quotient overflows.
   assign head = XW'(num[NW-1:QW]);

   always_ff @(posedge clock) begin
      rem_ff[0] <= DW'(head);
      low_ff[0] <= num[QW-1:0];
      den_ff[0] <= den;
      q_ff[0]   <= '0;
      ovf_ff[0] <= (head >= XW'(den));
   end

   // One quotient bit per stage.
   for (genvar i = 1; i <= QW; i++) begin : g_step
      logic [DW:0] trial;
      logic        ge;
      assign trial = {rem_ff[i-1], low_ff[i-1][QW-1]};
      assign ge    = (trial >= {1'b0, den_ff[i-1]});
      always_ff @(posedge clock) begin
         rem_ff[i] <= ge ? DW'(trial - {1'b0, den_ff[i-1]}) : DW'(trial);
         low_ff[i] <= low_ff[i-1] << 1;
         den_ff[i] <= den_ff[i-1];
         q_ff[i]   <= {q_ff[i-1][QW-2:0], ge};
         ovf_ff[i] <= ovf_ff[i-1];
      end
   end

   // Round half away from zero on the magnitude, then clamp.
   assign rnd  = ({rem_ff[QW], 1'b0} >= {1'b0, den_ff[QW]});
   assign qsum = {1'b0, q_ff[QW]} + (QW+1)'(rnd);

   always_ff @(posedge clock) begin
      quo_ff <= (ovf_ff[QW] || qsum[QW]) ? '1 : qsum[QW-1:0];
   end

   assign quo = quo_ff;

endmodule

FILE: hw/rtl/ccoll_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module ccoll_sqrt #(
   parameter int RW = 17
) (
   input  logic            clock,
   input  logic [2*RW-1:0] rad,
   output logic [RW-1:0]   root
);

   logic [RW+1:0]   rem_ff  [0:RW-1];
   logic [RW-1:0]   root_ff [0:RW-1];
   logic [2*RW-1:0] x_ff    [0:RW-1];

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic [RW+1:0]   prev_rem;
      logic [RW-1:0]   prev_root;
      logic [2*RW-1:0] prev_x;
      logic [RW+1:0]   trial;
      logic [RW+1:0]   test;
      logic            ge;

      // The first stage starts from the radicand itself.
      if (k == 0) begin : g_first
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_x    = rad;
      end else begin : g_next
         assign prev_rem  = rem_ff[k-1];
         assign prev_root = root_ff[k-1];
         assign prev_x    = x_ff[k-1];
      end

      // Bring down two radicand bits and try the next root bit.
      assign trial = {prev_rem[RW-1:0], prev_x[2*RW-1:2*RW-2]};
      assign test  = {prev_root, 2'b01};
      assign ge    = (trial >= test);

      always_ff @(posedge clock) begin
         rem_ff[k]  <= ge ? (trial - test) : trial;
         root_ff[k] <= {prev_root[RW-2:0], ge};
         x_ff[k]    <= prev_x << 2;
      end
   end

   assign root = root_ff[RW-1];

endmodule

FILE: hw/rtl/ccoll_checker.sv
// Port-level checker for the circle collision block and its bind.
`include "circle_pair_elastic_collision_assert.svh"

module ccoll_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_hit
);

   // No word may appear in the cycle after a reset.
   `CCOLL_ASSERT_NXT(a_reset_clears, clock, reset, !rsp_valid, "response word right after reset")

   // A hit is only reported with a response word.
   `CCOLL_ASSERT_IMP(a_hit_with_word, clock, reset, rsp_hit, rsp_valid, "hit without word")

   // The pipeline takes a request word every cycle.
   `CCOLL_ASSERT_IMP(a_never_busy, clock, reset, start, !busy, "request refused")

endmodule

bind circle_pair_elastic_collision ccoll_checker u_ccoll_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp_hit  (rsp_hit)
);

FILE: bench/tb_circle_pair_elastic_collision.sv
// Self-checking testbench for the circle pair elastic collision block.
module tb_circle_pair_elastic_collision;
   import ccoll_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = 42;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PAIRS = 1450;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic [RADIUS_WIDTH-1:0] radius_type;

   typedef struct {
      coord_type ax, ay, avx, avy;
      radius_type ar;
      coord_type bx, by, bvx, bvy;
      radius_type br;
   } pair_type;

   typedef struct {
      coord_type ax, ay, avx, avy, bx, by, bvx, bvy;
      logic hit;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type req_a_pos_x = '0, req_a_pos_y = '0, req_a_vel_x = '0, req_a_vel_y = '0;
   coord_type req_b_pos_x = '0, req_b_pos_y = '0, req_b_vel_x = '0, req_b_vel_y = '0;
   radius_type req_a_radius = '0, req_b_radius = '0;
   logic rsp_valid, rsp_hit;
   coord_type rsp_new_a_pos_x, rsp_new_a_pos_y, rsp_new_a_vel_x, rsp_new_a_vel_y;
   coord_type rsp_new_b_pos_x, rsp_new_b_pos_y, rsp_new_b_vel_x, rsp_new_b_vel_y;

   outcome_type pending_outcomes[$];
   int error_count = 0;
   int cycle_count = 0;

   circle_pair_elastic_collision dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_pos_x(req_a_pos_x), .req_a_pos_y(req_a_pos_y),
      .req_a_vel_x(req_a_vel_x), .req_a_vel_y(req_a_vel_y),
      .req_a_radius(req_a_radius),
      .req_b_pos_x(req_b_pos_x), .req_b_pos_y(req_b_pos_y),
      .req_b_vel_x(req_b_vel_x), .req_b_vel_y(req_b_vel_y),
      .req_b_radius(req_b_radius),
      .rsp_valid(rsp_valid),
      .rsp_new_a_pos_x(rsp_new_a_pos_x), .rsp_new_a_pos_y(rsp_new_a_pos_y),
      .rsp_new_a_vel_x(rsp_new_a_vel_x), .rsp_new_a_vel_y(rsp_new_a_vel_y),
      .rsp_new_b_pos_x(rsp_new_b_pos_x), .rsp_new_b_pos_y(rsp_new_b_pos_y),
      .rsp_new_b_vel_x(rsp_new_b_vel_x), .rsp_new_b_vel_y(rsp_new_b_vel_y),
      .rsp_hit(rsp_hit)
   );

   // Free-running clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Integer square root, rounded down.
   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned root, bitv;
      root = 64'd0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Quotient rounded to nearest with ties away from zero, clamped to 2^61, then signed.
   function automatic longint rounded_quotient(input logic [127:0] num,
                                               input logic [127:0] den, input logic neg);
      logic [127:0] q, rem;
      if (den == 0) return 0;
      q = num / den;
      rem = num % den;
      if ((rem << 1) >= den) q = q + 128'd1;
      if (q > (128'd1 << 61)) q = 128'd1 << 61;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic coord_type clamp_coord(input longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return coord_type'(v);
   endfunction

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   // Collision predictor: separation along the centre line, then elastic impulse.
   function automatic outcome_type resolve_collision(input pair_type p);
      outcome_type o;
      longint ax, ay, avx, avy, bx, by, bvx, bvy, dx, dy, dot, mx, my, s;
      longint nax, nay, navx, navy, nbx, nby, nbvx, nbvy;
      longint unsigned adx, ady, d2, center_dist, gap, m1, m2;
      logic [127:0] vden, adot;
      logic hit;
      ax = longint'(p.ax); ay = longint'(p.ay); avx = longint'(p.avx); avy = longint'(p.avy);
      bx = longint'(p.bx); by = longint'(p.by); bvx = longint'(p.bvx); bvy = longint'(p.bvy);
      s = (longint'(p.ar) + longint'(p.br)) << FB;
      dx = ax - bx;
      dy = ay - by;
      adx = magnitude(dx);
      ady = magnitude(dy);
      nax = ax; nay = ay; navx = avx; navy = avy;
      nbx = bx; nby = by; nbvx = bvx; nbvy = bvy;
      hit = 1'b0;
      if (adx < s && ady < s) begin
         d2 = adx * adx + ady * ady;
         if (d2 != 0 && d2 < s * s) begin
            center_dist = floor_sqrt(d2);
            gap = s - center_dist;
            mx = rounded_quotient(128'(adx) * 128'(gap), 128'(2 * center_dist), dx > 0);
            my = rounded_quotient(128'(ady) * 128'(gap), 128'(2 * center_dist), dy > 0);
            m1 = longint'(p.ar) * longint'(p.ar);
            m2 = longint'(p.br) * longint'(p.br);
            dot = dx * (avx - bvx) + dy * (avy - bvy);
            adot = 128'(magnitude(dot));
            vden = 128'(m1 + m2) * 128'(d2);
            nax = ax - mx; nay = ay - my;
            nbx = bx + mx; nby = by + my;
            navx = avx - rounded_quotient(128'(2 * m2 * adx) * adot, vden, (dx < 0) != (dot < 0));
            navy = avy - rounded_quotient(128'(2 * m2 * ady) * adot, vden, (dy < 0) != (dot < 0));
            nbvx = bvx + rounded_quotient(128'(2 * m1 * adx) * adot, vden, (dx < 0) != (dot < 0));
            nbvy = bvy + rounded_quotient(128'(2 * m1 * ady) * adot, vden, (dy < 0) != (dot < 0));
            hit = 1'b1;
         end
      end
      o.ax = clamp_coord(nax); o.ay = clamp_coord(nay);
      o.avx = clamp_coord(navx); o.avy = clamp_coord(navy);
      o.bx = clamp_coord(nbx); o.by = clamp_coord(nby);
      o.bvx = clamp_coord(nbvx); o.bvy = clamp_coord(nbvy);
      o.hit = hit;
      return o;
   endfunction

   // Record the expected outcome of every accepted word.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         pair_type p;
         p.ax = req_a_pos_x; p.ay = req_a_pos_y; p.avx = req_a_vel_x; p.avy = req_a_vel_y;
         p.ar = req_a_radius;
         p.bx = req_b_pos_x; p.by = req_b_pos_y; p.bvx = req_b_vel_x; p.bvy = req_b_vel_y;
         p.br = req_b_radius;
         pending_outcomes.push_back(resolve_collision(p));
      end
   end

   task automatic check_field(input string name, input logic [CW-1:0] want,
                              input logic [CW-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         error_count++;
      end
   endtask

   // Compare each response word with the oldest expected outcome.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         outcome_type o;
         if (pending_outcomes.size() == 0) begin
            $error("response word with no outstanding request");
            error_count++;
         end else begin
            o = pending_outcomes.pop_front();
            check_field("new_a_pos_x", o.ax, rsp_new_a_pos_x);
            check_field("new_a_pos_y", o.ay, rsp_new_a_pos_y);
            check_field("new_a_vel_x", o.avx, rsp_new_a_vel_x);
            check_field("new_a_vel_y", o.avy, rsp_new_a_vel_y);
            check_field("new_b_pos_x", o.bx, rsp_new_b_pos_x);
            check_field("new_b_pos_y", o.by, rsp_new_b_pos_y);
            check_field("new_b_vel_x", o.bvx, rsp_new_b_vel_x);
            check_field("new_b_vel_y", o.bvy, rsp_new_b_vel_y);
            check_field("hit", CW'(o.hit), CW'(rsp_hit));
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_circle_pair_elastic_collision: errors");
         $finish;
      end
   end

   // Drive one word and hold it until the block takes it.
   task automatic send_pair(input pair_type p);
      start <= 1'b1;
      req_a_pos_x <= p.ax; req_a_pos_y <= p.ay; req_a_vel_x <= p.avx; req_a_vel_y <= p.avy;
      req_a_radius <= p.ar;
      req_b_pos_x <= p.bx; req_b_pos_y <= p.by; req_b_vel_x <= p.bvx; req_b_vel_y <= p.bvy;
      req_b_radius <= p.br;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Mostly back to back, sometimes short gaps, rarely long ones.
   task automatic random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) idle_cycles(0);
      else if (r < 95) idle_cycles($urandom_range(1, 4));
      else idle_cycles($urandom_range(10, 60));
   endtask

   task automatic wait_drained();
      idle_cycles(1);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic pair_type make_pair(input longint ax, ay, avx, avy, input int ar,
                                          input longint bx, by, bvx, bvy, input int br);
      pair_type p;
      p.ax = coord_type'(ax); p.ay = coord_type'(ay);
      p.avx = coord_type'(avx); p.avy = coord_type'(avy);
      p.ar = radius_type'(ar);
      p.bx = coord_type'(bx); p.by = coord_type'(by);
      p.bvx = coord_type'(bvx); p.bvy = coord_type'(bvy);
      p.br = radius_type'(br);
      return p;
   endfunction

   function automatic coord_type any_coord();
      return coord_type'($urandom);
   endfunction

   // Random coordinate within a few hundred steps of either end of the range.
   function automatic longint edge_coord();
      if ($urandom_range(0, 1) != 0) begin
         return longint'(8388607) - longint'($urandom_range(0, 300));
      end
      return longint'(-8388608) + longint'($urandom_range(0, 300));
   endfunction

   // Overlapping or near-touching pair with random content, optionally near the range edge.
   function automatic pair_type close_pair();
      pair_type p;
      int s, span;
      longint base_x, base_y;
      p.ar = radius_type'($urandom_range(0, 99) < 5 ? 0 : $urandom_range(1, 255));
      p.br = radius_type'($urandom_range(0, 99) < 5 ? 0 : $urandom_range(1, 255));
      if ($urandom_range(0, 9) == 0) begin
         p.ar = radius_type'($urandom_range(0, 3));
         p.br = radius_type'($urandom_range(0, 3));
      end
      s = (int'(p.ar) + int'(p.br)) << FB;
      span = (s == 0) ? 1 : s;
      if ($urandom_range(0, 4) == 0) begin
         base_x = edge_coord();
         base_y = edge_coord();
      end else begin
         base_x = longint'($signed(any_coord()) / 2);
         base_y = longint'($signed(any_coord()) / 2);
      end
      p.bx = clamp_coord(base_x);
      p.by = clamp_coord(base_y);
      p.ax = clamp_coord(base_x + longint'($urandom_range(0, 2 * span)) - longint'(span));
      p.ay = clamp_coord(base_y + longint'($urandom_range(0, 2 * span)) - longint'(span));
      if ($urandom_range(0, 49) == 0) begin
         p.ax = p.bx;
         p.ay = p.by;
      end
      if ($urandom_range(0, 2) == 0) begin
         p.avx = any_coord(); p.avy = any_coord(); p.bvx = any_coord(); p.bvy = any_coord();
      end else begin
         p.avx = coord_type'($signed(16'($urandom)));
         p.avy = coord_type'($signed(16'($urandom)));
         p.bvx = coord_type'($signed(16'($urandom)));
         p.bvy = coord_type'($signed(16'($urandom)));
      end
      return p;
   endfunction

   // Field extremes, coincident centres, zero radii, exact touching and saturation.
   task automatic test_directed();
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(make_pair(8388607, 8388607, 8388607, 8388607, 255,
                          -8388608, -8388608, -8388608, -8388608, 255));
      send_pair(make_pair(100, 200, 300, -400, 10, 100, 200, -50, 60, 20));
      send_pair(make_pair(0, 0, 256, 0, 1, 512, 0, 0, 0, 1));
      send_pair(make_pair(0, 0, 256, 0, 1, 511, 0, 0, 0, 1));
      send_pair(make_pair(0, 0, 8388607, 8388607, 255, 1, 1, -8388608, -8388608, 255));
      send_pair(make_pair(8388607, 8388607, 0, 0, 255, 8388600, 8388600, 0, 0, 255));
      send_pair(make_pair(-8388608, -8388608, 0, 0, 255, -8388600, -8388600, 0, 0, 255));
      send_pair(make_pair(0, 0, 1000, 0, 0, 100, 0, -1000, 0, 40));
      send_pair(make_pair(0, 0, 1000, 0, 40, 100, 0, -1000, 0, 0));
      send_pair(make_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      send_pair(make_pair(-300, 7000, -8388608, 8388607, 30, 500, 6000, 8388607, -8388608, 200));
      send_pair(make_pair(0, 0, 5, 5, 255, 0, -65279, 0, 0, 0));
      send_pair(make_pair(0, 0, 5, 5, 255, 0, -65280, 0, 0, 0));
      send_pair(make_pair(1, -1, -1, 1, 128, -1, 1, 1, -1, 127));
      wait_drained();
   endtask

   // Random stream: mostly close pairs, the rest unconstrained words.
   task automatic test_random();
      pair_type p;
      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         if ($urandom_range(0, 99) < 80) begin
            p = close_pair();
         end else begin
            p.ax = any_coord(); p.ay = any_coord(); p.avx = any_coord(); p.avy = any_coord();
            p.bx = any_coord(); p.by = any_coord(); p.bvx = any_coord(); p.bvy = any_coord();
            p.ar = radius_type'($urandom); p.br = radius_type'($urandom);
         end
         send_pair(p);
         random_gap();
      end
   endtask

   // Sender holds off until the pipeline is empty, then resumes.
   task automatic test_drain_and_resume();
      for (int i = 0; i < 20; i++) send_pair(close_pair());
      wait_drained();
      for (int i = 0; i < 20; i++) send_pair(close_pair());
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_drain_and_resume();
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && pending_outcomes.size() == 0) begin
         $display("tb_circle_pair_elastic_collision: clean");
      end else begin
         $display("tb_circle_pair_elastic_collision: errors");
      end
      $finish;
   end

endmodule
